@@ rtl/llcst_pkg.sv @@
package llcst_pkg;

	localparam int TBL_DEPTH = 32;
	localparam int IDX_W     = $clog2(TBL_DEPTH);
	localparam int USED_W    = $clog2(TBL_DEPTH + 1);

	localparam logic [1:0] OP_TEXT = 2'd0;
	localparam logic [1:0] OP_EOL  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	typedef struct packed {
		logic text;
		logic eol;
		logic rd_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic at_last;
	} sts_t;

	function automatic logic is_letter(input logic [7:0] b);
		is_letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

endpackage

@@ rtl/llcst_ctrl.sv @@
module llcst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    operation,
	input  llcst_pkg::sts_t sts,
	output llcst_pkg::cmd_t cmd,
	output logic          busy
);
	import llcst_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t state_q;
	logic   accept;

	assign accept = start && !busy;
	assign busy   = (state_q == ST_READ);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (operation)
						OP_TEXT: cmd.text     = 1'b1;
						OP_EOL:  cmd.eol      = 1'b1;
						OP_READ: cmd.rd_start = 1'b1;
						default: ;
					endcase
				end
			end
			ST_READ: cmd.emit = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && operation == OP_READ) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (sts.empty || sts.at_last) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

@@ rtl/llcst_dp.sv @@
module llcst_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    char_byte,
	input  llcst_pkg::cmd_t cmd,
	output llcst_pkg::sts_t sts,
	output logic          result_strobe,
	output logic          entry_valid,
	output logic [15:0]   line_number,
	output logic [15:0]   line_letters,
	output logic [31:0]   total_letters,
	output logic          overflow,
	output logic          last
);
	import llcst_pkg::*;

	logic [15:0]       tbl_ln_q  [TBL_DEPTH];
	logic [15:0]       tbl_cnt_q [TBL_DEPTH];
	logic [USED_W-1:0] used_q;
	logic [15:0]       cur_q;
	logic [15:0]       lines_q;
	logic [31:0]       total_q;
	logic              drop_q;
	logic [IDX_W-1:0]  rd_idx_q;

	logic [15:0]       lines_nxt;
	logic              full;
	logic              letter;
	logic [TBL_DEPTH-1:0] ge;
	logic [15:0]       ins_ln  [TBL_DEPTH];
	logic [15:0]       ins_cnt [TBL_DEPTH];

	assign letter    = is_letter(char_byte);
	assign full      = (used_q == USED_W'(TBL_DEPTH));
	assign lines_nxt = (lines_q != 16'hFFFF) ? lines_q + 16'd1 : lines_q;

	assign sts.empty   = (used_q == '0);
	assign sts.at_last = ({1'b0, rd_idx_q} + USED_W'(1) == used_q);

	// sorted table: ge is monotonic, unused slots count as greater
	for (genvar g = 0; g < TBL_DEPTH; g++) begin : g_ins
		assign ge[g] = (USED_W'(g) >= used_q) || (tbl_cnt_q[g] >= cur_q);
		if (g == 0) begin : g_first
			assign ins_ln[g]  = ge[g] ? lines_nxt : tbl_ln_q[g];
			assign ins_cnt[g] = ge[g] ? cur_q : tbl_cnt_q[g];
		end else begin : g_rest
			assign ins_ln[g]  = !ge[g] ? tbl_ln_q[g] :
			                    ge[g-1] ? tbl_ln_q[g-1] : lines_nxt;
			assign ins_cnt[g] = !ge[g] ? tbl_cnt_q[g] :
			                    ge[g-1] ? tbl_cnt_q[g-1] : cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eol && !full) begin
			for (int k = 0; k < TBL_DEPTH; k++) begin
				tbl_ln_q[k]  <= ins_ln[k];
				tbl_cnt_q[k] <= ins_cnt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			cur_q    <= '0;
			lines_q  <= '0;
			total_q  <= '0;
			drop_q   <= 1'b0;
			rd_idx_q <= '0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.emit;
			if (cmd.text && letter) begin
				if (cur_q != 16'hFFFF) begin
					cur_q <= cur_q + 16'd1;
				end
				if (total_q != 32'hFFFF_FFFF) begin
					total_q <= total_q + 32'd1;
				end
			end
			if (cmd.eol) begin
				lines_q <= lines_nxt;
				cur_q   <= '0;
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					used_q <= used_q + USED_W'(1);
				end
			end
			if (cmd.rd_start) begin
				rd_idx_q <= '0;
			end else if (cmd.emit) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			entry_valid   <= !sts.empty;
			line_number   <= sts.empty ? 16'd0 : tbl_ln_q[rd_idx_q];
			line_letters  <= sts.empty ? 16'd0 : tbl_cnt_q[rd_idx_q];
			total_letters <= total_q;
			overflow      <= drop_q;
			last          <= sts.empty || sts.at_last;
		end
	end

endmodule

@@ rtl/line_letter_count_sorted_table_unit.sv @@
// channel   ports                                         handshake
// command   operation, char_byte                          start & !busy
// result    entry_valid, line_number, line_letters,       result_strobe, one cycle
//           total_letters, overflow, last
//
// Text bytes and end-of-line commands are taken while busy stays low.
// Readout holds busy high from its accept until the last entry is read, one table
// entry per cycle (one empty result for an empty table); then start is taken again.
// Each result is registered and shows in the cycle after its table read.
// Insertion is a parallel compare and shift over the register table.
// arst_n clears counters, fill count and overflow flag; the receiver cannot stall.
module line_letter_count_sorted_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  char_byte,
	output logic        result_strobe,
	output logic        entry_valid,
	output logic [15:0] line_number,
	output logic [15:0] line_letters,
	output logic [31:0] total_letters,
	output logic        overflow,
	output logic        last
);
	import llcst_pkg::*;

	cmd_t cmd;
	sts_t sts;

	llcst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	llcst_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_byte     (char_byte),
		.cmd           (cmd),
		.sts           (sts),
		.result_strobe (result_strobe),
		.entry_valid   (entry_valid),
		.line_number   (line_number),
		.line_letters  (line_letters),
		.total_letters (total_letters),
		.overflow      (overflow),
		.last          (last)
	);

endmodule
